FILE: rtl/core/wfhc_pkg.sv
package wfhc_pkg;

   localparam int HDR_BYTES  = 36;
   localparam int LEN_W      = 13;
   localparam int NUM_ATTRS  = 20;
   localparam int IDX_W      = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MGMT_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CTRL_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SSID_LIMIT = 2'd2;

   // attribute numbers
   localparam int ATTR_TYPE      = 0;
   localparam int ATTR_SUBTYPE   = 1;
   localparam int ATTR_DIR       = 2;
   localparam int ATTR_CORRUPT   = 3;
   localparam int ATTR_SEQ       = 4;
   localparam int ATTR_FRAG      = 5;
   localparam int ATTR_MOREFRAG  = 6;
   localparam int ATTR_PRIVACY   = 7;
   localparam int ATTR_DEST      = 8;
   localparam int ATTR_SRC       = 9;
   localparam int ATTR_BSSID     = 10;
   localparam int ATTR_SSIDLEN   = 11;
   localparam int ATTR_SSIDBLANK = 12;
   localparam int ATTR_RATE      = 13;
   localparam int ATTR_CHANNEL   = 14;
   localparam int ATTR_INTERVAL  = 15;
   localparam int ATTR_REASON    = 16;
   localparam int ATTR_TSTAMP    = 17;
   localparam int ATTR_DATASIZE  = 18;
   localparam int ATTR_HDROFF    = 19;

   localparam logic [1:0] FT_MGMT = 2'd0;
   localparam logic [1:0] FT_CTRL = 2'd1;
   localparam logic [1:0] FT_DATA = 2'd2;

   localparam logic [3:0] SUB_PROBE_REQ  = 4'd4;
   localparam logic [3:0] SUB_PROBE_RSP  = 4'd5;
   localparam logic [3:0] SUB_BEACON     = 4'd8;
   localparam logic [3:0] SUB_ATIM       = 4'd9;
   localparam logic [3:0] SUB_DISASSOC   = 4'd10;
   localparam logic [3:0] SUB_CTRL_FIRST = 4'd11;
   localparam logic [3:0] SUB_ACK        = 4'd13;
   localparam logic [63:0] SUB_UNKNOWN   = 64'd16;

   localparam logic [7:0] EID_SSID  = 8'd0;
   localparam logic [7:0] EID_RATES = 8'd1;
   localparam logic [7:0] EID_CHAN  = 8'd3;
   localparam logic [7:0] EID_NONE  = 8'hFF;

   localparam logic [1:0] PH_ID   = 2'd0;
   localparam logic [1:0] PH_LEN  = 2'd1;
   localparam logic [1:0] PH_BODY = 2'd2;

   localparam logic [LEN_W-1:0] MIN_FRAME   = 13'd24;
   localparam logic [LEN_W-1:0] WALK_PROBE  = 13'd24;
   localparam logic [LEN_W-1:0] WALK_FIXED  = 13'd36;
   localparam logic [LEN_W-1:0] MIN_4ADDR   = 13'd30;
   localparam logic [63:0]      MAC_BCAST   = 64'hFFFF_FFFF_FFFF;

   typedef logic [HDR_BYTES-1:0][7:0] hdr_type;

   // everything the back end needs about one finished frame
   typedef struct packed {
      hdr_type          hdr;
      logic [LEN_W-1:0] len;
      logic             mid_element;
      logic [2:0]       found;
      logic [7:0]       ssid_bytes;
      logic             ssid_nonzero;
      logic [6:0]       peak_rate;
      logic [7:0]       channel;
      logic             ssid_corrupt;
   } snap_type;

   function automatic logic [63:0] mac_at(hdr_type h, int off);
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < 6; i++) m = {m[55:0], h[off+i]};
      return m;
   endfunction

   function automatic logic [63:0] le16_at(hdr_type h, int off);
      return {48'd0, h[off+1], h[off]};
   endfunction

endpackage

FILE: rtl/core/wfhc_front.sv
module wfhc_front
   import wfhc_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_valid,
   input  logic [7:0]       byte_data,
   input  logic             byte_end,
   input  logic [7:0]       ssid_limit,
   output logic             push,
   output snap_type         push_data
);

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME_BYTES);

   logic [LEN_W-1:0] count_ff, count_in;
   hdr_type          hdr_ff, hdr_in;
   logic [1:0]       phase_ff, phase_in;
   logic [7:0]       eid_ff, eid_in;
   logic [7:0]       left_ff, left_in;
   logic [2:0]       found_ff, found_in;
   logic [7:0]       ssid_bytes_ff, ssid_bytes_in;
   logic             ssid_nz_ff, ssid_nz_in;
   logic [6:0]       peak_ff, peak_in;
   logic [7:0]       chan_ff, chan_in;
   logic             corrupt_ff, corrupt_in;

   logic             active, walking;
   logic [3:0]       sub;
   logic [LEN_W-1:0] start;

   always_comb begin
      active  = count_ff < MAX_LEN;
      sub     = hdr_ff[0][7:4];
      start   = (sub == SUB_PROBE_REQ) ? WALK_PROBE : WALK_FIXED;
      walking = (hdr_ff[0][3:2] == FT_MGMT) &&
                (sub == SUB_PROBE_REQ || sub == SUB_PROBE_RSP || sub == SUB_BEACON) &&
                (count_ff >= start) && active;

      hdr_in        = hdr_ff;
      count_in      = count_ff;
      phase_in      = phase_ff;
      eid_in        = eid_ff;
      left_in       = left_ff;
      found_in      = found_ff;
      ssid_bytes_in = ssid_bytes_ff;
      ssid_nz_in    = ssid_nz_ff;
      peak_in       = peak_ff;
      chan_in       = chan_ff;
      corrupt_in    = corrupt_ff;

      if (active) begin
         if (count_ff == '0) hdr_in = '0;
         if (count_ff < LEN_W'(HDR_BYTES)) hdr_in[count_ff[5:0]] = byte_data;
         count_in = count_ff + 1'b1;
      end

      if (walking) begin
         unique case (phase_ff)
            PH_ID: begin
               eid_in   = byte_data;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               left_in = byte_data;
               if (eid_ff == EID_SSID) begin
                  if (found_ff[0]) eid_in = EID_NONE;
                  else begin
                     found_in[0]   = 1'b1;
                     ssid_bytes_in = byte_data;
                     ssid_nz_in    = 1'b0;
                     if (byte_data > ssid_limit) corrupt_in = 1'b1;
                  end
               end else if (eid_ff == EID_RATES) begin
                  if (found_ff[1]) eid_in = EID_NONE;
                  else found_in[1] = 1'b1;
               end else if (eid_ff == EID_CHAN) begin
                  if (found_ff[2]) eid_in = EID_NONE;
                  else begin
                     found_in[2] = 1'b1;
                     chan_in     = '0;
                  end
               end
               phase_in = (byte_data != 8'd0) ? PH_BODY : PH_ID;
            end
            default: begin
               if (eid_ff == EID_SSID) begin
                  if (byte_data != 8'd0) ssid_nz_in = 1'b1;
               end else if (eid_ff == EID_RATES) begin
                  if (byte_data[6:0] > peak_ff) peak_in = byte_data[6:0];
               end else if (eid_ff == EID_CHAN) begin
                  chan_in = byte_data;
                  eid_in  = EID_NONE;
               end
               left_in = left_ff - 1'b1;
               if (left_in == 8'd0) phase_in = PH_ID;
            end
         endcase
      end

      push                   = byte_valid && byte_end && (count_in >= MIN_FRAME);
      push_data.hdr          = hdr_in;
      push_data.len          = count_in;
      push_data.mid_element  = phase_in != PH_ID;
      push_data.found        = found_in;
      push_data.ssid_bytes   = ssid_bytes_in;
      push_data.ssid_nonzero = ssid_nz_in;
      push_data.peak_rate    = peak_in;
      push_data.channel      = chan_in;
      push_data.ssid_corrupt = corrupt_in;
   end

   always_ff @(posedge clock) begin
      if (byte_valid) hdr_ff <= hdr_in;
      if (reset) begin
         count_ff      <= '0;
         phase_ff      <= PH_ID;
         eid_ff        <= '0;
         left_ff       <= '0;
         found_ff      <= '0;
         ssid_bytes_ff <= '0;
         ssid_nz_ff    <= 1'b0;
         peak_ff       <= '0;
         chan_ff       <= '0;
         corrupt_ff    <= 1'b0;
      end else if (byte_valid) begin
         if (byte_end) begin
            count_ff      <= '0;
            phase_ff      <= PH_ID;
            eid_ff        <= '0;
            left_ff       <= '0;
            found_ff      <= '0;
            ssid_bytes_ff <= '0;
            ssid_nz_ff    <= 1'b0;
            peak_ff       <= '0;
            chan_ff       <= '0;
            corrupt_ff    <= 1'b0;
         end else begin
            count_ff      <= count_in;
            phase_ff      <= phase_in;
            eid_ff        <= eid_in;
            left_ff       <= left_in;
            found_ff      <= found_in;
            ssid_bytes_ff <= ssid_bytes_in;
            ssid_nz_ff    <= ssid_nz_in;
            peak_ff       <= peak_in;
            chan_ff       <= chan_in;
            corrupt_ff    <= corrupt_in;
         end
      end
   end

endmodule

FILE: rtl/core/wfhc_queue.sv
module wfhc_queue
   import wfhc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  snap_type push_data,
   output logic     not_full,
   input  logic     pop,
   output logic     not_empty,
   output snap_type head
);

   snap_type   mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] fill_ff;

   assign not_full  = fill_ff != 2'd2;
   assign not_empty = fill_ff != 2'd0;
   assign head      = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         if (push && !pop) fill_ff <= fill_ff + 1'b1;
         else if (pop && !push) fill_ff <= fill_ff - 1'b1;
      end
   end

endmodule

FILE: rtl/core/wfhc_back.sv
module wfhc_back
   import wfhc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  snap_valid,
   input  snap_type              snap,
   output logic                  snap_pop,
   input  logic [LEN_W-1:0]      mgmt_limit,
   input  logic [LEN_W-1:0]      ctrl_limit,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [71:0]           rsp_tdata,
   output logic                  rsp_tlast
);

   logic [63:0]      vals_ff [NUM_ATTRS];
   logic [63:0]      v [NUM_ATTRS];
   logic             busy_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             valid_ff;
   logic [71:0]      data_ff;
   logic             last_ff;
   logic             out_free;

   hdr_type          h;
   logic [1:0]       ftype;
   logic [3:0]       sub;
   logic [63:0]      dir;
   logic [LEN_W-1:0] len, start;
   logic             ssid_ok, rate_ok;

   assign snap_pop   = snap_valid && !busy_ff;
   assign out_free   = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   always_comb begin
      h       = snap.hdr;
      len     = snap.len;
      ftype   = h[0][3:2];
      sub     = h[0][7:4];
      start   = (sub == SUB_PROBE_REQ) ? WALK_PROBE : WALK_FIXED;
      ssid_ok = snap.found[0];
      rate_ok = snap.found[1];
      unique case (h[1][1:0])
         2'd0:    dir = 64'd1;
         2'd1:    dir = 64'd3;
         2'd2:    dir = 64'd2;
         default: dir = 64'd4;
      endcase
      for (int i = 0; i < NUM_ATTRS; i++) v[i] = '0;
      v[ATTR_TYPE]     = {62'd0, ftype};
      v[ATTR_SUBTYPE]  = SUB_UNKNOWN;
      v[ATTR_DIR]      = dir;
      v[ATTR_SEQ]      = {52'd0, h[23], h[22][7:4]};
      v[ATTR_FRAG]     = {60'd0, h[22][3:0]};
      v[ATTR_MOREFRAG] = {63'd0, h[1][2]};

      if (ftype == FT_MGMT) begin
         v[ATTR_DIR] = '0;
         if (len > mgmt_limit) begin
            v[ATTR_CORRUPT] = 64'd1;
         end else begin
            if (sub == SUB_PROBE_REQ) begin
               v[ATTR_HDROFF] = 64'd24;
            end else begin
               v[ATTR_HDROFF]  = 64'd36;
               v[ATTR_PRIVACY] = {63'd0, h[34][4]};
               if (h[34][1:0] == 2'd2) v[ATTR_DIR] = 64'd1;
               v[ATTR_TSTAMP]  = {h[31], h[30], h[29], h[28], h[27], h[26], h[25], h[24]};
            end
            if ((sub == SUB_PROBE_REQ || sub == SUB_PROBE_RSP || sub == SUB_BEACON) &&
                (len <= start || snap.mid_element)) begin
               v[ATTR_CORRUPT] = 64'd1;
            end else if ((sub == SUB_PROBE_REQ || sub == SUB_PROBE_RSP || sub == SUB_BEACON) &&
                         ssid_ok && snap.ssid_corrupt) begin
               v[ATTR_SSIDLEN] = {56'd0, snap.ssid_bytes};
               v[ATTR_CORRUPT] = 64'd1;
            end else begin
               if (sub == SUB_PROBE_REQ || sub == SUB_PROBE_RSP || sub == SUB_BEACON) begin
                  if (ssid_ok) begin
                     v[ATTR_SSIDLEN] = {56'd0, snap.ssid_bytes};
                     if (snap.ssid_bytes != 8'd0 && !snap.ssid_nonzero)
                        v[ATTR_SSIDBLANK] = 64'd1;
                  end
                  if (rate_ok) v[ATTR_RATE] = {57'd0, snap.peak_rate};
                  if (snap.found[2]) v[ATTR_CHANNEL] = {56'd0, snap.channel};
               end
               if (sub == SUB_PROBE_REQ) begin
                  v[ATTR_SUBTYPE] = {60'd0, sub};
                  v[ATTR_DIR]     = 64'd3;
                  v[ATTR_SRC]     = mac_at(h, 10);
                  v[ATTR_BSSID]   = mac_at(h, 10);
                  if (!ssid_ok) v[ATTR_CORRUPT] = 64'd1;
               end else if (sub <= 4'd3 || sub == SUB_PROBE_RSP || sub == SUB_BEACON ||
                            (sub >= SUB_ATIM && sub <= 4'd12)) begin
                  v[ATTR_SUBTYPE] = {60'd0, sub};
                  v[ATTR_DEST]    = mac_at(h, 4);
                  v[ATTR_SRC]     = mac_at(h, 10);
                  v[ATTR_BSSID]   = mac_at(h, 16);
                  if (sub == SUB_ATIM) v[ATTR_DIR] = '0;
                  if (sub >= SUB_DISASSOC) v[ATTR_REASON] = le16_at(h, 24);
                  if (sub == SUB_BEACON) begin
                     v[ATTR_INTERVAL] = le16_at(h, 32);
                     if (mac_at(h, 4) != MAC_BCAST || !ssid_ok || !rate_ok)
                        v[ATTR_CORRUPT] = 64'd1;
                  end
               end
            end
         end
      end else if (ftype == FT_CTRL) begin
         if (len > ctrl_limit) begin
            v[ATTR_CORRUPT] = 64'd1;
         end else begin
            v[ATTR_DIR] = '0;
            if (sub >= SUB_CTRL_FIRST) begin
               v[ATTR_SUBTYPE] = {60'd0, sub};
               if (sub == SUB_ACK) v[ATTR_DEST] = mac_at(h, 4);
            end
         end
      end else if (ftype == FT_DATA) begin
         if (sub > 4'd6) begin
            v[ATTR_CORRUPT] = 64'd1;
         end else begin
            v[ATTR_SUBTYPE] = {60'd0, sub};
            unique case (h[1][1:0])
               2'd0: begin
                  v[ATTR_DEST]   = mac_at(h, 4);
                  v[ATTR_SRC]    = mac_at(h, 10);
                  v[ATTR_BSSID]  = (mac_at(h, 16) == '0) ? mac_at(h, 10) : mac_at(h, 16);
                  v[ATTR_HDROFF] = 64'd24;
               end
               2'd2: begin
                  v[ATTR_DEST]   = mac_at(h, 4);
                  v[ATTR_BSSID]  = mac_at(h, 10);
                  v[ATTR_SRC]    = mac_at(h, 16);
                  v[ATTR_HDROFF] = 64'd24;
               end
               2'd1: begin
                  v[ATTR_BSSID]  = mac_at(h, 4);
                  v[ATTR_SRC]    = mac_at(h, 10);
                  v[ATTR_DEST]   = mac_at(h, 16);
                  v[ATTR_HDROFF] = 64'd24;
               end
               default: begin
                  if (len >= MIN_4ADDR) begin
                     v[ATTR_BSSID]  = mac_at(h, 10);
                     v[ATTR_SRC]    = mac_at(h, 24);
                     v[ATTR_DEST]   = mac_at(h, 4);
                     v[ATTR_HDROFF] = 64'd30;
                  end
               end
            endcase
            if (h[1][1:0] == 2'd3 && len < MIN_4ADDR) begin
               v[ATTR_CORRUPT] = 64'd1;
            end else begin
               v[ATTR_DATASIZE] = {51'd0, len - v[ATTR_HDROFF][LEN_W-1:0]};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (snap_pop) begin
         for (int i = 0; i < NUM_ATTRS; i++) vals_ff[i] <= v[i];
      end
      if (out_free && busy_ff) begin
         data_ff <= {3'd0, vals_ff[idx_ff], idx_ff};
         last_ff <= idx_ff == IDX_W'(NUM_ATTRS - 1);
      end
      if (reset) begin
         busy_ff  <= 1'b0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (out_free) valid_ff <= busy_ff;
         if (snap_pop) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (out_free && busy_ff) begin
            idx_ff <= idx_ff + 1'b1;
            if (idx_ff == IDX_W'(NUM_ATTRS - 1)) busy_ff <= 1'b0;
         end
      end
   end

endmodule

FILE: rtl/core/wlan_frame_header_classifier.sv
// frame bytes are taken one per cycle whenever the frame queue has room
// results: 20 beats per frame of 24 bytes or more, via queue, attribute regs and output reg
// result side sends one beat per cycle while rsp_tready is high, with an idle gap between frames
// a two-entry frame queue lets the byte side run on while results drain
// reset (synchronous, active high) clears parse state, queue and output; limits go to 512/128/32
module wlan_frame_header_classifier
   import wfhc_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // frame_byte
   input  logic                  req_tlast,   // frame_end
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [71:0]           rsp_tdata,   // attr_id [4:0], attr_value [68:5], zero pad
   output logic                  rsp_tlast,   // attr_last
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [LEN_W-1:0] mgmt_limit_ff, ctrl_limit_ff;
   logic [7:0]       ssid_limit_ff;
   logic             beat, push, not_full, not_empty, pop;
   snap_type         push_data, head;

   assign req_tready = not_full;
   assign beat       = req_tvalid && not_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         mgmt_limit_ff <= 13'd512;
         ctrl_limit_ff <= 13'd128;
         ssid_limit_ff <= 8'd32;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_MGMT_LIMIT: mgmt_limit_ff <= csr_wdata;
            CSR_CTRL_LIMIT: ctrl_limit_ff <= csr_wdata;
            CSR_SSID_LIMIT: ssid_limit_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   wfhc_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (beat),
      .byte_data  (req_tdata),
      .byte_end   (req_tlast),
      .ssid_limit (ssid_limit_ff),
      .push       (push),
      .push_data  (push_data)
   );

   wfhc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .not_full  (not_full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   wfhc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (not_empty),
      .snap       (head),
      .snap_pop   (pop),
      .mgmt_limit (mgmt_limit_ff),
      .ctrl_limit (ctrl_limit_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
